// ----- hdl/rtsm_pkg.sv -----
package rtsm_pkg;

  localparam int ADDR_W  = 24;
  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_PITCH  = 3'd0;
  localparam logic [2:0] REG_DEST_X = 3'd1;
  localparam logic [2:0] REG_DEST_Y = 3'd2;
  localparam logic [2:0] REG_MIN    = 3'd3;
  localparam logic [2:0] REG_MANY   = 3'd4;

  localparam logic [7:0] MIN_CODE_RST  = 8'd248;
  localparam logic [7:0] MANY_CODE_RST = 8'd248;

  // op kinds passed from front to back
  localparam logic [2:0] K_IGNORE = 3'd0;
  localparam logic [2:0] K_START  = 3'd1;
  localparam logic [2:0] K_WHI    = 3'd2;
  localparam logic [2:0] K_HLO    = 3'd3;
  localparam logic [2:0] K_HHI    = 3'd4;
  localparam logic [2:0] K_PIXEL  = 3'd5;
  localparam logic [2:0] K_MANY   = 3'd6;
  localparam logic [2:0] K_SKIP   = 3'd7;

  typedef struct packed {
    logic [15:0] surface_pitch;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [7:0]  min_skip_code;
    logic [7:0]  long_skip_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       start_of_sprite;
  } in_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [7:0]        pixel_value;
    logic              sprite_done;
  } out_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [8:0] count;
  } op_t;

endpackage

// ----- hdl/rle_transparent_sprite_mirror_blit.sv -----
// Mirrored run-length sprite decoder: one result item per input byte, in order. A front
// stage classifies each byte (header, opaque pixel, run code, run count) into a two-entry
// queue; a back stage walks the sprite and fills a single output register. The last
// height byte takes a destination base multiply, then an add. Opaque pixels and skips
// step through the sprite rows they cross, one per cycle, then emit their item; a skip
// that runs off the end of the sprite ends it at the last row and emits done.
// Registers (APB, byte address 4*i): pitch, dest_x, dest_y, min code, many code; write
// them only while the block is idle. The destination base is taken at the last header byte.
module rle_transparent_sprite_mirror_blit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  rtsm_pkg::in_t                    in_data,
  output logic                             in_stall,
  output logic                             out_valid,
  output rtsm_pkg::out_t                   out_data,
  input  logic                             out_stall,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rtsm_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rtsm_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic       q_full, push, pop, op_valid;
  op_t        push_op, op;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surface_pitch  <= 16'd0;
      cfg_r.dest_x         <= 16'd0;
      cfg_r.dest_y         <= 16'd0;
      cfg_r.min_skip_code  <= MIN_CODE_RST;
      cfg_r.long_skip_code <= MANY_CODE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PITCH:  cfg_r.surface_pitch  <= pwdata[15:0];
        REG_DEST_X: cfg_r.dest_x         <= pwdata[15:0];
        REG_DEST_Y: cfg_r.dest_y         <= pwdata[15:0];
        REG_MIN:    cfg_r.min_skip_code  <= pwdata[7:0];
        REG_MANY:   cfg_r.long_skip_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PITCH:  prdata = {16'h0000, cfg_r.surface_pitch};
      REG_DEST_X: prdata = {16'h0000, cfg_r.dest_x};
      REG_DEST_Y: prdata = {16'h0000, cfg_r.dest_y};
      REG_MIN:    prdata = {24'h000000, cfg_r.min_skip_code};
      REG_MANY:   prdata = {24'h000000, cfg_r.long_skip_code};
      default:    prdata = 32'h0000_0000;
    endcase
  end

  rtsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  rtsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_op  (push_op),
    .full     (q_full),
    .pop      (pop),
    .op_valid (op_valid),
    .op       (op)
  );

  rtsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_valid  (op_valid),
    .op        (op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/rtsm_front.sv -----
module rtsm_front (
  input  logic           clk,
  input  logic           rst_n,
  input  rtsm_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  rtsm_pkg::in_t  in_data,
  output logic           in_stall,
  input  logic           q_full,
  output logic           push,
  output rtsm_pkg::op_t  push_op
);
  import rtsm_pkg::*;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_WHI   = 3'd1;
  localparam logic [2:0] F_HLO   = 3'd2;
  localparam logic [2:0] F_HHI   = 3'd3;
  localparam logic [2:0] F_BODY  = 3'd4;
  localparam logic [2:0] F_COUNT = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] b;

  assign b        = in_data.stream_byte;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    phase_nxt     = phase_r;
    push_op.kind  = K_IGNORE;
    push_op.data  = b;
    push_op.count = 9'd1;
    if (in_data.start_of_sprite) begin
      push_op.kind = K_START;
      phase_nxt    = F_WHI;
    end else begin
      unique case (phase_r)
        F_WHI: begin
          push_op.kind = K_WHI;
          phase_nxt    = F_HLO;
        end
        F_HLO: begin
          push_op.kind = K_HLO;
          phase_nxt    = F_HHI;
        end
        F_HHI: begin
          push_op.kind = K_HHI;
          phase_nxt    = F_BODY;
        end
        F_BODY: begin
          if (b < cfg.min_skip_code) begin
            push_op.kind = K_PIXEL;
          end else if (b == cfg.long_skip_code) begin
            push_op.kind = K_MANY;
            phase_nxt    = F_COUNT;
          end else begin
            push_op.kind  = K_SKIP;
            push_op.count = 9'd256 - {1'b0, b};
          end
        end
        F_COUNT: begin
          push_op.kind  = K_SKIP;
          push_op.count = (b == 8'd0) ? 9'd1 : {1'b0, b};
          phase_nxt     = F_BODY;
        end
        default: begin
          push_op.kind = K_IGNORE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= F_IDLE;
    end else if (push) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ----- hdl/rtsm_queue.sv -----
module rtsm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rtsm_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          op_valid,
  output rtsm_pkg::op_t op
);
  import rtsm_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/rtsm_back.sv -----
module rtsm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  rtsm_pkg::cfg_t cfg,
  input  logic           op_valid,
  input  rtsm_pkg::op_t  op,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output rtsm_pkg::out_t out_data
);
  import rtsm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_BASE = 2'd2;
  localparam logic [1:0] S_ADV  = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic              active_r, active_nxt;
  logic [15:0]       width_r, width_nxt;
  logic [15:0]       height_r, height_nxt;
  logic [15:0]       row_r, row_nxt;
  logic [15:0]       col_r, col_nxt;
  logic [16:0]       total_r, total_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic              res_wv_r, res_wv_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [7:0]        res_pix_r, res_pix_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              can_emit, emit;
  out_t              emit_data;
  logic [16:0]       row_inc;
  logic              empty;

  assign can_emit  = !out_valid_r || !out_stall;
  assign row_inc   = {1'b0, row_r} + 17'd1;
  assign empty     = (width_r == 16'd0) || (height_r == 16'd0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    st_nxt       = st_r;
    active_nxt   = active_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    total_nxt    = total_r;
    base_nxt     = base_r;
    prod_nxt     = prod_r;
    res_wv_nxt   = res_wv_r;
    res_addr_nxt = res_addr_r;
    res_pix_nxt  = res_pix_r;
    pop          = 1'b0;
    emit         = 1'b0;
    emit_data    = '0;
    unique case (st_r)
      S_IDLE: begin
        if (op_valid && can_emit) begin
          pop = 1'b1;
          if (op.kind == K_START) begin
            width_nxt  = {8'h00, op.data};
            height_nxt = 16'd0;
            row_nxt    = 16'd0;
            col_nxt    = 16'd0;
            base_nxt   = '0;
            active_nxt = 1'b1;
            emit       = 1'b1;
          end else if (op.kind == K_IGNORE || !active_r) begin
            emit                  = 1'b1;
            emit_data.sprite_done = 1'b1;
          end else begin
            case (op.kind)
              K_WHI: begin
                width_nxt[15:8] = op.data;
                emit            = 1'b1;
              end
              K_HLO: begin
                height_nxt = {8'h00, op.data};
                emit       = 1'b1;
              end
              K_HHI: begin
                height_nxt[15:8] = op.data;
                row_nxt          = 16'd0;
                col_nxt          = 16'd0;
                st_nxt           = S_MUL;
              end
              K_PIXEL: begin
                res_wv_nxt   = 1'b1;
                res_pix_nxt  = op.data;
                res_addr_nxt = base_r + ADDR_W'(width_r - 16'd1 - col_r);
                total_nxt    = {1'b0, col_r} + {8'h00, op.count};
                st_nxt       = S_ADV;
              end
              K_MANY: begin
                emit = 1'b1;
              end
              K_SKIP: begin
                res_wv_nxt   = 1'b0;
                res_pix_nxt  = 8'd0;
                res_addr_nxt = '0;
                total_nxt    = {1'b0, col_r} + {8'h00, op.count};
                st_nxt       = S_ADV;
              end
              default: begin
                emit                  = 1'b1;
                emit_data.sprite_done = 1'b1;
              end
            endcase
          end
        end
      end
      S_MUL: begin
        prod_nxt = cfg.dest_y * cfg.surface_pitch;
        st_nxt   = S_BASE;
      end
      S_BASE: begin
        if (can_emit) begin
          base_nxt              = ADDR_W'(prod_r + {16'h0000, cfg.dest_x});
          emit                  = 1'b1;
          emit_data.sprite_done = empty;
          active_nxt            = !empty;
          st_nxt                = S_IDLE;
        end
      end
      S_ADV: begin
        emit_data.write_valid = res_wv_r;
        emit_data.write_addr  = res_addr_r;
        emit_data.pixel_value = res_pix_r;
        if (total_r >= {1'b0, width_r}) begin
          // one row crossed per cycle
          if (row_inc >= {1'b0, height_r}) begin
            if (can_emit) begin
              emit                  = 1'b1;
              emit_data.sprite_done = 1'b1;
              active_nxt            = 1'b0;
              st_nxt                = S_IDLE;
            end
          end else begin
            total_nxt = total_r - {1'b0, width_r};
            row_nxt   = row_inc[15:0];
            base_nxt  = base_r + ADDR_W'(cfg.surface_pitch);
          end
        end else if (can_emit) begin
          col_nxt = total_r[15:0];
          emit    = 1'b1;
          st_nxt  = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= 16'd0;
      height_r    <= 16'd0;
      row_r       <= 16'd0;
      col_r       <= 16'd0;
      base_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    prod_r     <= prod_nxt;
    res_wv_r   <= res_wv_nxt;
    res_addr_r <= res_addr_nxt;
    res_pix_r  <= res_pix_nxt;
    out_data_r <= out_data_nxt;
  end

  a_adv_width: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ADV) |-> (width_r != 16'd0))
    else $error("row walk with zero width");

  a_base_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_BASE) |-> ($past(st_r) == S_MUL || $past(st_r) == S_BASE))
    else $error("base step not preceded by multiply");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (st_r == S_IDLE && op_valid && can_emit))
    else $error("op taken while busy");

  a_adv_active: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ADV) |-> active_r)
    else $error("row walk on inactive sprite");

endmodule

// ----- sim/rtsm_blit_checker.sv -----
`timescale 1ns / 100ps
module rtsm_blit_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  rtsm_pkg::in_t                in_data,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  rtsm_pkg::out_t               out_data,
  input  logic                         out_stall,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtsm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  output int                           mismatches,
  output int                           outstanding
);
  import rtsm_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_WIDTH_HI  = 3'd1;
  localparam logic [2:0] ST_HEIGHT_LO = 3'd2;
  localparam logic [2:0] ST_HEIGHT_HI = 3'd3;
  localparam logic [2:0] ST_BODY      = 3'd4;
  localparam logic [2:0] ST_COUNT     = 3'd5;

  localparam longint unsigned ADDR_MASK = (64'd1 << ADDR_W) - 64'd1;

  longint unsigned pitch, dest_x, dest_y, min_code, many_code;
  logic [2:0]      dec_state;
  longint unsigned spr_w, spr_h, row_idx, col_idx, row_base;
  out_t            write_q[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // covers n more pixels; returns 1 when the sprite is complete
  function automatic bit cover_run(longint unsigned n);
    longint unsigned total, rows, row;
    if (spr_w == 0) begin
      dec_state = ST_IDLE;
      return 1'b1;
    end
    total = col_idx + n;
    rows = total / spr_w;
    col_idx = total % spr_w;
    row = row_idx + rows;
    row_base = (row_base + rows * pitch) & ADDR_MASK;
    if (row >= spr_h) begin
      dec_state = ST_IDLE;
      row_idx = row & 64'hFFFF;
      return 1'b1;
    end
    row_idx = row;
    return 1'b0;
  endfunction

  function automatic out_t decode_byte(in_t item);
    out_t            res;
    longint unsigned b, addr;
    res = '0;
    b = 64'(item.stream_byte);
    if (item.start_of_sprite) begin
      spr_w = b;
      spr_h = 0;
      row_idx = 0;
      col_idx = 0;
      row_base = 0;
      dec_state = ST_WIDTH_HI;
    end else begin
      case (dec_state)
        ST_WIDTH_HI: begin
          spr_w |= b << 8;
          dec_state = ST_HEIGHT_LO;
        end
        ST_HEIGHT_LO: begin
          spr_h = b;
          dec_state = ST_HEIGHT_HI;
        end
        ST_HEIGHT_HI: begin
          spr_h |= b << 8;
          row_idx = 0;
          col_idx = 0;
          row_base = (dest_y * pitch + dest_x) & ADDR_MASK;
          if (spr_w == 0 || spr_h == 0) begin
            dec_state = ST_IDLE;
            res.sprite_done = 1'b1;
          end else begin
            dec_state = ST_BODY;
          end
        end
        ST_BODY: begin
          if (b < min_code) begin
            addr = (row_base + spr_w - 1 - col_idx) & ADDR_MASK;
            res.write_valid = 1'b1;
            res.pixel_value = item.stream_byte;
            res.write_addr = addr[ADDR_W-1:0];
            if (cover_run(1)) res.sprite_done = 1'b1;
          end else if (b == many_code) begin
            dec_state = ST_COUNT;
          end else if (cover_run(256 - b)) begin
            res.sprite_done = 1'b1;
          end
        end
        ST_COUNT: begin
          dec_state = ST_BODY;
          if (cover_run(b == 0 ? 1 : b)) res.sprite_done = 1'b1;
        end
        default: begin
          dec_state = ST_IDLE;
          res.sprite_done = 1'b1;
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      pitch = 0;
      dest_x = 0;
      dest_y = 0;
      min_code = 64'(MIN_CODE_RST);
      many_code = 64'(MANY_CODE_RST);
      dec_state = ST_IDLE;
      spr_w = 0;
      spr_h = 0;
      row_idx = 0;
      col_idx = 0;
      row_base = 0;
      write_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[rtsm_pkg::PADDR_W-1:2])
          REG_PITCH:  pitch = 64'(pwdata[15:0]);
          REG_DEST_X: dest_x = 64'(pwdata[15:0]);
          REG_DEST_Y: dest_y = 64'(pwdata[15:0]);
          REG_MIN:    min_code = 64'(pwdata[7:0]);
          REG_MANY:   many_code = 64'(pwdata[7:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) write_q.push_back(decode_byte(in_data));
      if (out_valid && !out_stall) begin
        if (write_q.size() == 0) begin
          report_mismatch("item with nothing expected", 64'(out_data), 0);
        end else begin
          want = write_q.pop_front();
          if (out_data.write_valid !== want.write_valid)
            report_mismatch("write_valid", 64'(out_data.write_valid), 64'(want.write_valid));
          if (out_data.write_addr !== want.write_addr)
            report_mismatch("write_addr", 64'(out_data.write_addr), 64'(want.write_addr));
          if (out_data.pixel_value !== want.pixel_value)
            report_mismatch("pixel_value", 64'(out_data.pixel_value), 64'(want.pixel_value));
          if (out_data.sprite_done !== want.sprite_done)
            report_mismatch("sprite_done", 64'(out_data.sprite_done), 64'(want.sprite_done));
        end
      end
    end
    outstanding = write_q.size();
  end

endmodule

// ----- sim/tb_rle_transparent_sprite_mirror_blit.sv -----
`timescale 1ns / 100ps
module tb_rle_transparent_sprite_mirror_blit;
  import rtsm_pkg::*;

  localparam int LIMIT = 5000000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  in_t                in_data = '0;
  logic               in_stall;
  logic               out_valid;
  out_t               out_data;
  logic               out_stall = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 mismatches;
  int                 outstanding;

  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  int          sent = 0;
  int unsigned cur_min = MIN_CODE_RST;
  int unsigned cur_many = MANY_CODE_RST;
  int          cycles = 0;

  rle_transparent_sprite_mirror_blit dut (.*);
  rtsm_blit_checker chk (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(logic [7:0] b, logic s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{stream_byte: b, start_of_sprite: s};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_header(int unsigned w, int unsigned h);
    send_item(w[7:0], 1'b1);
    send_item(w[15:8], 1'b0);
    send_item(h[7:0], 1'b0);
    send_item(h[15:8], 1'b0);
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  task automatic send_sprite();
    int unsigned     w, h, sel, n, cap, b, c;
    longint unsigned area, covered;
    sel = $urandom_range(99);
    if (sel < 4) begin
      repeat ($urandom_range(4, 1)) send_item(8'($urandom_range(255)), 1'b0);
      return;
    end
    if (sel < 8) begin
      // header cut short by a new start
      send_item(8'($urandom_range(255)), 1'b1);
      repeat ($urandom_range(2)) send_item(8'($urandom_range(255)), 1'b0);
      return;
    end
    w = $urandom_range(20, 1);
    h = $urandom_range(10, 1);
    cap = 80;
    if (sel < 13) begin
      if ($urandom_range(1)) begin
        w = 0;
        h = $urandom_range(65535);
      end else begin
        w = $urandom_range(65535);
        h = 0;
      end
    end else if (sel < 16) begin
      if ($urandom_range(1)) begin
        w = 65535;
        h = $urandom_range(3, 1);
      end else begin
        w = $urandom_range(2, 1);
        h = 65535;
      end
      cap = 30;
    end else if (sel < 26) begin
      w = $urandom_range(600, 21);
    end
    send_header(w, h);
    area = longint'(w) * h;
    covered = 0;
    n = 0;
    while (covered < area && n < cap) begin
      if ($urandom_range(99) < 2) return;
      sel = $urandom_range(99);
      if (sel < 10) b = cur_many;
      else if (sel < 65 && cur_min > 0) b = $urandom_range(cur_min - 1);
      else b = $urandom_range(255, ($urandom_range(1) && cur_min < 240) ? 240 : cur_min);
      send_item(8'(b), 1'b0);
      n++;
      if (b < cur_min) begin
        covered++;
      end else if (b == cur_many) begin
        c = $urandom_range(1) ? $urandom_range(255) : $urandom_range(3);
        send_item(8'(c), 1'b0);
        covered += (c == 0) ? 1 : c;
      end else begin
        covered += 256 - b;
      end
    end
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(3, 1)) send_item(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic set_config(int unsigned pitch_v, int unsigned dx, int unsigned dy,
                            int unsigned mn, int unsigned mny);
    drain();
    write_reg(REG_PITCH, pitch_v);
    write_reg(REG_DEST_X, dx);
    write_reg(REG_DEST_Y, dy);
    write_reg(REG_MIN, mn);
    write_reg(REG_MANY, mny);
    cur_min = mn;
    cur_many = mny;
  endtask

  task automatic run_phase(int unsigned pitch_v, int unsigned dx, int unsigned dy,
                           int unsigned mn, int unsigned mny, int idle, int stall,
                           int count, bit hold);
    int target;
    set_config(pitch_v, dx, dy, mn, mny);
    idle_pct = idle;
    stall_pct = stall;
    if (hold) hold_req = 1'b1;
    target = sent + count;
    while (sent < target) send_sprite();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    send_item(8'hFF, 1'b0);
    send_header(4, 4);
    send_item(8'h01, 1'b0);
    send_header(2, 1);
    send_item(8'h00, 1'b0);
    send_item(8'hF7, 1'b0);
    send_item(8'hAA, 1'b0);

    set_config(640, 100, 50, 248, 248);
    send_header(3, 2);
    send_item(8'h10, 1'b0);
    send_item(8'hF8, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFC, 1'b0);
    send_header(0, 5);

    run_phase(320, 17, 3, 248, 248, 0, 0, 260, 1'b0);
    run_phase(65535, 65535, 65535, 255, 255, 68, 0, 260, 1'b0);
    run_phase(0, 0, 0, 0, 0, 0, 68, 200, 1'b0);
    run_phase(1024, 300, 200, 128, 64, 7, 7, 260, 1'b0);
    run_phase(800, 5, 9, 248, 248, 0, 0, 260, 1'b1);
    run_phase(4093, 1, 40000, 200, 250, 68, 68, 200, 1'b0);
    run_phase(96, 40, 12, 16, 0, 0, 0, 160, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
